>>> design/apif_pkg.sv
// Shared types and constants of the average predictor image filter.
package apif_pkg;

    localparam int CHAN_W       = 8;
    localparam int NUM_CHAN     = 4;
    localparam int PIX_W        = CHAN_W * NUM_CHAN;
    localparam int WIDTH_REG_W  = 13;
    localparam int HEIGHT_REG_W = 16;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ENCODE_MODE    = 2'd0,
        REG_SINGLE_CHANNEL = 2'd1,
        REG_IMAGE_WIDTH    = 2'd2,
        REG_IMAGE_HEIGHT   = 2'd3
    } apif_reg_idx_t;

    // Operating mode, straight from the configuration registers.
    typedef struct packed {
        logic encode;
        logic single;
    } apif_mode_t;

    // Where a pixel sits in the frame.
    typedef struct packed {
        logic first_row;
        logic first_col;
        logic last_pix;
        logic up_is_left;
    } apif_pos_t;

endpackage

>>> design/average_predictor_image_filter.sv
// Top level of the average predictor image filter: line store and pipeline.
//
//  channel  ports                        direction  handshake
//  request  s_chan0_in..s_chan3_in       in         s_valid / s_ready
//  result   m_chan0_out..m_frame_last    out        m_valid / m_ready
//  config   cfg_index, cfg_data          in         cfg_we, no wait
//
// One pixel per clock sustained while m_ready stays high; a taken request is
// registered in the input stage, then in the result register behind m_valid.
// The rate is set by the line store: one read port at acceptance, one write
// port as a pixel leaves the input stage.
// Reset (aresetn low, synchronous) clears counters, modes, left neighbor and
// valids; width and height return to 1. The line store is not cleared.
// A stalled result holds the output register; the input stage still moves
// into it as soon as it empties, so no bubble is added.
module average_predictor_image_filter #(
    parameter int MAX_WIDTH = 4096
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_we,
    input  logic [apif_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [apif_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [apif_pkg::CHAN_W-1:0]     s_chan0_in,
    input  logic [apif_pkg::CHAN_W-1:0]     s_chan1_in,
    input  logic [apif_pkg::CHAN_W-1:0]     s_chan2_in,
    input  logic [apif_pkg::CHAN_W-1:0]     s_chan3_in,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [apif_pkg::CHAN_W-1:0]     m_chan0_out,
    output logic [apif_pkg::CHAN_W-1:0]     m_chan1_out,
    output logic [apif_pkg::CHAN_W-1:0]     m_chan2_out,
    output logic [apif_pkg::CHAN_W-1:0]     m_chan3_out,
    output logic                            m_frame_last
);
    import apif_pkg::*;

    localparam int COL_W = $clog2(MAX_WIDTH);

    // Position and mode of the next request.
    logic [COL_W-1:0]        cur_col, last_col;
    logic [HEIGHT_REG_W-1:0] cur_row, last_row;
    apif_pos_t               cur_pos;
    apif_mode_t              mode;

    // Input stage: registered request plus the line store read.
    logic             s1_valid_reg;
    logic [PIX_W-1:0] s1_pix_reg;
    apif_pos_t        s1_pos_reg;
    logic [COL_W-1:0] s1_col_reg;
    logic [PIX_W-1:0] up_reg;
    logic [PIX_W-1:0] left_reg;

    // Output stage.
    logic             m_valid_reg;
    logic [PIX_W-1:0] m_pix_reg;
    logic             m_last_reg;

    logic [PIX_W-1:0] res, keep;
    logic             s_accept, s1_adv;

    // Previous row; an entry is used only after the row above wrote it.
    logic [PIX_W-1:0] line_mem [MAX_WIDTH];

    // Advance the input stage whenever the output register is free or drains.
    assign s1_adv   = s1_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready  = !s1_valid_reg || s1_adv;
    assign s_accept = s_valid && s_ready;

    apif_frame_ctl #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_frame_ctl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .advance   (s_accept),
        .col       (cur_col),
        .last_col  (last_col),
        .row       (cur_row),
        .last_row  (last_row),
        .mode      (mode),
        .pos       (cur_pos)
    );

    apif_predict u_predict (
        .pix_in   (s1_pix_reg),
        .up_pix   (up_reg),
        .left_pix (left_reg),
        .pos      (s1_pos_reg),
        .mode     (mode),
        .res_out  (res),
        .keep_out (keep)
    );

    // Line store: write the kept pixel as it leaves, read the next column
    // above at acceptance. Same-address overlap only happens with a single
    // column, and the predictor takes the left neighbor there instead.
    always_ff @(posedge aclk) begin
        if (s1_adv) begin
            line_mem[s1_col_reg] <= keep;
        end
        if (s_accept) begin
            up_reg <= line_mem[cur_col];
        end
    end

    // Hold the request in the input stage; load the result register.
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            s1_pix_reg <= {s_chan3_in, s_chan2_in, s_chan1_in, s_chan0_in};
            s1_pos_reg <= cur_pos;
            s1_col_reg <= cur_col;
        end
        if (s1_adv) begin
            m_pix_reg  <= res;
            m_last_reg <= s1_pos_reg.last_pix;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
            left_reg     <= '0;
        end else begin
            if (s_accept) begin
                s1_valid_reg <= 1'b1;
            end else if (s1_adv) begin
                s1_valid_reg <= 1'b0;
            end
            if (s1_adv) begin
                m_valid_reg <= 1'b1;
                left_reg    <= keep;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_chan0_out  = m_pix_reg[0*CHAN_W +: CHAN_W];
    assign m_chan1_out  = m_pix_reg[1*CHAN_W +: CHAN_W];
    assign m_chan2_out  = m_pix_reg[2*CHAN_W +: CHAN_W];
    assign m_chan3_out  = m_pix_reg[3*CHAN_W +: CHAN_W];
    assign m_frame_last = m_last_reg;

`ifndef NO_ASSERTIONS
    // Column counter never runs past the last column of the frame.
    assert property (@(posedge aclk) disable iff (!aresetn)
        cur_col <= last_col)
        else $error("column counter beyond frame width");

    // Row counter never runs past the last row of the frame.
    assert property (@(posedge aclk) disable iff (!aresetn)
        cur_row <= last_row)
        else $error("row counter beyond frame height");

    // A request is never taken while the input stage is full and stuck.
    assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_accept && s1_valid_reg && !s1_adv))
        else $error("input stage overwritten");

    // A pixel leaving the input stage shows up as a result next cycle.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s1_adv |=> m_valid_reg)
        else $error("result lost between stages");
`endif

endmodule

>>> design/apif_frame_ctl.sv
// Configuration registers and raster position counters.
module apif_frame_ctl #(
    parameter int MAX_WIDTH = 4096
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_we,
    input  logic [apif_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [apif_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                              advance,
    output logic [$clog2(MAX_WIDTH)-1:0]      col,
    output logic [$clog2(MAX_WIDTH)-1:0]      last_col,
    output logic [apif_pkg::HEIGHT_REG_W-1:0] row,
    output logic [apif_pkg::HEIGHT_REG_W-1:0] last_row,
    output apif_pkg::apif_mode_t              mode,
    output apif_pkg::apif_pos_t               pos
);
    import apif_pkg::*;

    localparam int COL_W = $clog2(MAX_WIDTH);

    logic [COL_W-1:0]        col_reg, col_next;
    logic [COL_W-1:0]        last_col_reg;
    logic [HEIGHT_REG_W-1:0] row_reg, row_next;
    logic [HEIGHT_REG_W-1:0] last_row_reg;
    apif_mode_t              mode_reg;
    logic [31:0]             wr_width;
    logic [COL_W-1:0]        wr_last_col;
    logic [HEIGHT_REG_W-1:0] wr_last_row;
    logic                    col_end, row_end, geom_wr;

    // Clamp width to 1..MAX_WIDTH, height to 1 or more; store last col/row.
    always_comb begin
        wr_width = 32'(cfg_data[WIDTH_REG_W-1:0]);
        if (wr_width == 32'd0) begin
            wr_last_col = '0;
        end else if (wr_width > 32'(MAX_WIDTH)) begin
            wr_last_col = COL_W'(MAX_WIDTH - 1);
        end else begin
            wr_last_col = COL_W'(wr_width - 32'd1);
        end
        if (cfg_data[HEIGHT_REG_W-1:0] == '0) begin
            wr_last_row = '0;
        end else begin
            wr_last_row = cfg_data[HEIGHT_REG_W-1:0] - HEIGHT_REG_W'(1);
        end
    end

    assign col_end = (col_reg == last_col_reg);
    assign row_end = (row_reg == last_row_reg);
    assign geom_wr = cfg_we && ((cfg_index == REG_IMAGE_WIDTH) ||
                                (cfg_index == REG_IMAGE_HEIGHT));

    always_comb begin
        col_next = col_reg;
        row_next = row_reg;
        priority if (geom_wr) begin
            col_next = '0;
            row_next = '0;
        end else if (advance) begin
            if (col_end) begin
                col_next = '0;
                row_next = row_end ? '0 : row_reg + HEIGHT_REG_W'(1);
            end else begin
                col_next = col_reg + COL_W'(1);
            end
        end else begin
            // Hold the position while no request is taken.
            col_next = col_reg;
            row_next = row_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg      <= '0;
            row_reg      <= '0;
            last_col_reg <= '0;
            last_row_reg <= '0;
            mode_reg     <= '0;
        end else begin
            col_reg <= col_next;
            row_reg <= row_next;
            if (cfg_we) begin
                unique case (apif_reg_idx_t'(cfg_index))
                    REG_ENCODE_MODE:    mode_reg.encode <= cfg_data[0];
                    REG_SINGLE_CHANNEL: mode_reg.single <= cfg_data[0];
                    REG_IMAGE_WIDTH:    last_col_reg    <= wr_last_col;
                    REG_IMAGE_HEIGHT:   last_row_reg    <= wr_last_row;
                    default: ;
                endcase
            end
        end
    end

    assign col      = col_reg;
    assign last_col = last_col_reg;
    assign row      = row_reg;
    assign last_row = last_row_reg;
    assign mode     = mode_reg;

    always_comb begin
        pos.first_row  = (row_reg == '0);
        pos.first_col  = (col_reg == '0);
        pos.last_pix   = col_end && row_end;
        // With one column the pixel above is the pixel just before.
        pos.up_is_left = (last_col_reg == '0);
    end

endmodule

>>> design/apif_predict.sv
// Per-channel average prediction, residual and kept neighbor.
module apif_predict (
    input  logic [apif_pkg::PIX_W-1:0] pix_in,
    input  logic [apif_pkg::PIX_W-1:0] up_pix,
    input  logic [apif_pkg::PIX_W-1:0] left_pix,
    input  apif_pkg::apif_pos_t        pos,
    input  apif_pkg::apif_mode_t       mode,
    output logic [apif_pkg::PIX_W-1:0] res_out,
    output logic [apif_pkg::PIX_W-1:0] keep_out
);
    import apif_pkg::*;

    logic [PIX_W-1:0] up_sel;

    assign up_sel = pos.up_is_left ? left_pix : up_pix;

    always_comb begin
        logic [CHAN_W-1:0] x, l, u, pred, res;
        logic [CHAN_W:0]   sum;
        res_out  = '0;
        keep_out = '0;
        for (int c = 0; c < NUM_CHAN; c++) begin
            x   = pix_in[c*CHAN_W +: CHAN_W];
            l   = left_pix[c*CHAN_W +: CHAN_W];
            u   = up_sel[c*CHAN_W +: CHAN_W];
            sum = {1'b0, u} + {1'b0, l};
            priority if (pos.first_row) begin
                pred = l;
            end else if (pos.first_col) begin
                pred = u;
            end else begin
                pred = sum[CHAN_W:1];
            end
            res = (pos.first_row && pos.first_col) ? x : pred - x;
            // Drop the upper channels in single-channel mode.
            if (c == 0 || !mode.single) begin
                res_out[c*CHAN_W +: CHAN_W]  = res;
                keep_out[c*CHAN_W +: CHAN_W] = mode.encode ? x : res;
            end
        end
    end

endmodule

>>> tb/average_predictor_image_filter_tb.sv
// Self-checking testbench for the average predictor image filter: directed and random pixels.
`timescale 1ns / 100ps

module average_predictor_image_filter_tb;

    import apif_pkg::*;

    localparam int MAX_W      = 4096;
    localparam int RANDOM_PIX = 500;
    localparam int HOLD_LONG  = 80;     // receiver hold-off that backs up the pipe
    localparam int TIMEOUT_NS = 200_000;

    typedef logic [NUM_CHAN-1:0][CHAN_W-1:0] pixel_t;

    typedef struct packed {
        pixel_t chans;
        logic   last;
    } result_t;

    typedef enum logic {ROW_PIXEL, ROW_WRITE} row_kind_t;

    // One line of the directed plan: either a register write or a pixel request,
    // optionally with its result typed in by hand.
    typedef struct {
        row_kind_t     kind;
        apif_reg_idx_t idx;
        logic [15:0]   data;
        pixel_t        px;
        bit            pinned;
        pixel_t        exp_px;
        bit            exp_last;
    } plan_row_t;

    localparam int PLAN_LEN = 35;

    logic                  aclk = 1'b0;
    logic                  aresetn;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  s_valid;
    logic                  s_ready;
    logic [CHAN_W-1:0]     s_chan0_in, s_chan1_in, s_chan2_in, s_chan3_in;
    logic                  m_valid;
    logic                  m_ready;
    logic [CHAN_W-1:0]     m_chan0_out, m_chan1_out, m_chan2_out, m_chan3_out;
    logic                  m_frame_last;

    // Filter state as the testbench sees it; starts at its reset values.
    logic                    enc_mode    = 1'b0;
    logic                    single_mode = 1'b0;
    logic [WIDTH_REG_W-1:0]  width_reg   = 13'd1;
    logic [HEIGHT_REG_W-1:0] height_reg  = 16'd1;
    pixel_t                  left_px     = '0;
    int unsigned             col_cnt     = 0;
    int unsigned             row_cnt     = 0;
    pixel_t                  prev_row [MAX_W];

    result_t pending_results [$];

    int  pixels_sent   = 0;
    int  results_seen  = 0;
    int  frames_closed = 0;
    int  mismatches    = 0;
    int  settings_used = 0;
    bit  tx_idle_on    = 1'b1;
    bit  rx_idle_on    = 1'b1;
    int  rx_hold_cycles = 0;

    plan_row_t plan [PLAN_LEN];

    average_predictor_image_filter #(
        .MAX_WIDTH(MAX_W)
    ) uut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_chan0_in  (s_chan0_in),
        .s_chan1_in  (s_chan1_in),
        .s_chan2_in  (s_chan2_in),
        .s_chan3_in  (s_chan3_in),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_chan0_out (m_chan0_out),
        .m_chan1_out (m_chan1_out),
        .m_chan2_out (m_chan2_out),
        .m_chan3_out (m_chan3_out),
        .m_frame_last(m_frame_last)
    );

    // 2 ns clock.
    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // Width register as the block uses it: zero acts as one, saturate at the line size.
    function automatic int unsigned eff_width(input logic [WIDTH_REG_W-1:0] w);
        if (w == 0) return 1;
        if (w > MAX_W) return MAX_W;
        return w;
    endfunction

    function automatic int unsigned eff_height(input logic [HEIGHT_REG_W-1:0] h);
        return (h == 0) ? 1 : h;
    endfunction

    // Work out the residual (or reconstruction) of one pixel and advance the
    // neighbor state: left pixel, line store and the raster position.
    function automatic result_t filter_pixel(input pixel_t px);
        int unsigned w, h, col, row, c;
        pixel_t      up, kept;
        logic [8:0]  sum;
        logic [7:0]  pred;
        result_t     r;
        w    = eff_width(width_reg);
        h    = eff_height(height_reg);
        col  = (col_cnt >= w) ? 0 : col_cnt;
        row  = (row_cnt >= h) ? 0 : row_cnt;
        up   = prev_row[col];
        kept = '0;
        r    = '0;
        for (c = 0; c < NUM_CHAN; c++) begin
            if (c == 0 || !single_mode) begin
                if (row == 0 && col == 0) begin
                    r.chans[c] = px[c];
                end else begin
                    if (row == 0) begin
                        pred = left_px[c];
                    end else if (col == 0) begin
                        pred = up[c];
                    end else begin
                        sum  = {1'b0, up[c]} + {1'b0, left_px[c]};
                        pred = sum[8:1];
                    end
                    r.chans[c] = pred - px[c];
                end
                // Encode keeps the original pixel, decode keeps the rebuilt one.
                kept[c] = enc_mode ? px[c] : r.chans[c];
            end
        end
        r.last = (col == w - 1) && (row == h - 1);
        prev_row[col] = kept;
        left_px       = kept;
        col++;
        if (col >= w) begin
            col = 0;
            row++;
            if (row >= h) row = 0;
        end
        col_cnt = col;
        row_cnt = row;
        return r;
    endfunction

    // Drive one register write; call at a falling edge, return at the next one
    // with the write enable still high so back-to-back writes need no gap.
    task automatic write_reg(input apif_reg_idx_t idx, input logic [CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge aclk);
        case (idx)
            REG_ENCODE_MODE:    enc_mode    = data[0];
            REG_SINGLE_CHANNEL: single_mode = data[0];
            REG_IMAGE_WIDTH: begin
                width_reg = data[WIDTH_REG_W-1:0];
                col_cnt   = 0;
                row_cnt   = 0;
            end
            REG_IMAGE_HEIGHT: begin
                height_reg = data[HEIGHT_REG_W-1:0];
                col_cnt    = 0;
                row_cnt    = 0;
            end
            default: ;
        endcase
        @(negedge aclk);
    endtask

    // Offer one pixel request, after a random gap if gaps are enabled, and hold it until accepted.
    // A pinned result replaces the computed one in the expected queue.
    task automatic send_pixel(input pixel_t px, input bit pinned, input result_t fixed);
        int      gap;
        result_t want;
        gap = tx_idle_on ? $urandom_range(0, 4) : 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid    <= 1'b1;
        s_chan0_in <= px[0];
        s_chan1_in <= px[1];
        s_chan2_in <= px[2];
        s_chan3_in <= px[3];
        do @(posedge aclk); while (!s_ready);
        want = filter_pixel(px);
        if (pinned) want = fixed;
        pending_results.push_back(want);
        pixels_sent++;
        @(negedge aclk);
    endtask

    // Drop valid, wait for every outstanding result, then let the pipe settle.
    task automatic wait_idle(input int settle_cycles);
        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(negedge aclk);
        repeat (settle_cycles) @(negedge aclk);
    endtask

    // Result side: stall for a random gap before each result while stalls are enabled, or hold off
    // for a long stretch when asked so the block fills and stalls its input.
    initial begin : result_sink
        int stall;
        m_ready = 1'b0;
        wait (aresetn === 1'b1);
        @(negedge aclk);
        forever begin
            if (rx_hold_cycles > 0) begin
                stall          = rx_hold_cycles;
                rx_hold_cycles = 0;
            end else begin
                stall = rx_idle_on ? $urandom_range(0, 4) : 0;
            end
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
            @(negedge aclk);
        end
    end

    // Compare each accepted result with the oldest expectation.
    always @(posedge aclk) begin : result_check
        result_t got, want;
        int      c;
        if (aresetn && m_valid && m_ready) begin
            got.chans = {m_chan3_out, m_chan2_out, m_chan1_out, m_chan0_out};
            got.last  = m_frame_last;
            results_seen++;
            if (pending_results.size() == 0) begin
                mismatches++;
                $display("%0t ns: result %h/%b with nothing expected", $time,
                         got.chans, got.last);
            end else begin
                want = pending_results.pop_front();
                if (want.last) frames_closed++;
                for (c = 0; c < NUM_CHAN; c++) begin
                    if (got.chans[c] !== want.chans[c]) begin
                        mismatches++;
                        $display("%0t ns: chan%0d_out expected %02h, got %02h", $time, c,
                                 want.chans[c], got.chans[c]);
                    end
                end
                if (got.last !== want.last) begin
                    mismatches++;
                    $display("%0t ns: frame_last expected %b, got %b", $time,
                             want.last, got.last);
                end
            end
        end
    end

    // Hard stop in case the block hangs.
    initial begin
        #(TIMEOUT_NS);
        $display("timeout: %0d requests sent, %0d results seen", pixels_sent, results_seen);
        $display("average_predictor_image_filter: mismatch");
        $finish;
    end

    initial begin : stimulus
        int          i, k, n, w, h, ew, eh;
        bit          in_writes, flip_mode;
        logic        enc_bit, single_bit;
        int          random_sent;

        // Directed plan. Pixels are written ch3..ch0; results are typed in only
        // where they are obvious, the rest go through the predictor.
        plan = '{
            // Reset geometry is 1x1 decode: every pixel is a frame start, passes as is.
            '{ROW_PIXEL, REG_ENCODE_MODE, 16'h0, 32'h0000_0000, 1'b1, 32'h0000_0000, 1'b1},
            '{ROW_PIXEL, REG_ENCODE_MODE, 16'h0, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF, 1'b1},
            '{ROW_PIXEL, REG_ENCODE_MODE, 16'h0, 32'hF00F_A55A, 1'b1, 32'hF00F_A55A, 1'b1},
            // 3x2 encode: left prediction, up prediction, averages, then frame wrap.
            '{ROW_WRITE, REG_ENCODE_MODE, 16'h1, '0, 1'b0, '0, 1'b0},
            '{ROW_WRITE, REG_IMAGE_WIDTH, 16'd3, '0, 1'b0, '0, 1'b0},
            '{ROW_WRITE, REG_IMAGE_HEIGHT, 16'd2, '0, 1'b0, '0, 1'b0},
            '{ROW_PIXEL, REG_ENCODE_MODE, 16'h0, 32'h4030_2010, 1'b1, 32'h4030_2010, 1'b0},
            '{ROW_PIXEL, REG_ENCODE_MODE, 16'h0, 32'h4030_2010, 1'b1, 32'h0000_0000, 1'b0},
            '{ROW_PIXEL, REG_ENCODE_MODE, 16'h0, 32'h8001_FF00, 1'b0, '0, 1'b0},
            '{ROW_PIXEL, REG_ENCODE_MODE, 16'h0, 32'h1234_5678, 1'b0, '0, 1'b0},
            '{ROW_PIXEL, REG_ENCODE_MODE, 16'h0, 32'hFFFF_FFFF, 1'b0, '0, 1'b0},
            '{ROW_PIXEL, REG_ENCODE_MODE, 16'h0, 32'h0000_0000, 1'b0, '0, 1'b0},
            '{ROW_PIXEL, REG_ENCODE_MODE, 16'h0, 32'h7777_7777, 1'b1, 32'h7777_7777, 1'b0},
            // Single channel, zero width and height: 1x1, upper channels forced to zero.
            '{ROW_WRITE, REG_SINGLE_CHANNEL, 16'h1, '0, 1'b0, '0, 1'b0},
            '{ROW_WRITE, REG_ENCODE_MODE, 16'h0, '0, 1'b0, '0, 1'b0},
            '{ROW_WRITE, REG_IMAGE_WIDTH, 16'd0, '0, 1'b0, '0, 1'b0},
            '{ROW_WRITE, REG_IMAGE_HEIGHT, 16'd0, '0, 1'b0, '0, 1'b0},
            '{ROW_PIXEL, REG_ENCODE_MODE, 16'h0, 32'hFFFF_FFFF, 1'b1, 32'h0000_00FF, 1'b1},
            '{ROW_PIXEL, REG_ENCODE_MODE, 16'h0, 32'h0403_0201, 1'b1, 32'h0000_0001, 1'b1},
            // 2x2 decode with extreme bytes.
            '{ROW_WRITE, REG_SINGLE_CHANNEL, 16'h0, '0, 1'b0, '0, 1'b0},
            '{ROW_WRITE, REG_IMAGE_WIDTH, 16'd2, '0, 1'b0, '0, 1'b0},
            '{ROW_WRITE, REG_IMAGE_HEIGHT, 16'd2, '0, 1'b0, '0, 1'b0},
            '{ROW_PIXEL, REG_ENCODE_MODE, 16'h0, 32'hFF00_FF00, 1'b0, '0, 1'b0},
            '{ROW_PIXEL, REG_ENCODE_MODE, 16'h0, 32'h01FF_0080, 1'b0, '0, 1'b0},
            '{ROW_PIXEL, REG_ENCODE_MODE, 16'h0, 32'h7F80_FE01, 1'b0, '0, 1'b0},
            '{ROW_PIXEL, REG_ENCODE_MODE, 16'h0, 32'h00FF_FF00, 1'b0, '0, 1'b0},
            // All-ones geometry: width masks to 8191 and saturates, tallest frame.
            '{ROW_WRITE, REG_IMAGE_WIDTH, 16'hFFFF, '0, 1'b0, '0, 1'b0},
            '{ROW_WRITE, REG_IMAGE_HEIGHT, 16'hFFFF, '0, 1'b0, '0, 1'b0},
            '{ROW_PIXEL, REG_ENCODE_MODE, 16'h0, 32'hA5A5_A5A5, 1'b1, 32'hA5A5_A5A5, 1'b0},
            '{ROW_PIXEL, REG_ENCODE_MODE, 16'h0, 32'h5A5A_5A5A, 1'b0, '0, 1'b0},
            '{ROW_PIXEL, REG_ENCODE_MODE, 16'h0, 32'h0000_0000, 1'b0, '0, 1'b0},
            // Mode writes mid-frame with junk in the upper data bits: no restart.
            '{ROW_WRITE, REG_ENCODE_MODE, 16'hFFFF, '0, 1'b0, '0, 1'b0},
            '{ROW_WRITE, REG_SINGLE_CHANNEL, 16'hFFFE, '0, 1'b0, '0, 1'b0},
            '{ROW_PIXEL, REG_ENCODE_MODE, 16'h0, 32'h1357_9BDF, 1'b0, '0, 1'b0},
            '{ROW_PIXEL, REG_ENCODE_MODE, 16'h0, 32'hFFFF_FFFF, 1'b0, '0, 1'b0}
        };

        // Hold every input at a known value while reset is asserted.
        aresetn    = 1'b0;
        cfg_we     = 1'b0;
        cfg_index  = REG_ENCODE_MODE;
        cfg_data   = '0;
        s_valid    = 1'b0;
        s_chan0_in = '0;
        s_chan1_in = '0;
        s_chan2_in = '0;
        s_chan3_in = '0;
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Walk the directed plan; writes only go in once the block has drained.
        settings_used = 1;
        in_writes     = 1'b0;
        for (i = 0; i < PLAN_LEN; i++) begin
            if (plan[i].kind == ROW_WRITE) begin
                if (!in_writes) begin
                    wait_idle(4);
                    in_writes = 1'b1;
                    settings_used++;
                end
                write_reg(plan[i].idx, plan[i].data);
            end else begin
                if (in_writes) begin
                    cfg_we    <= 1'b0;
                    in_writes = 1'b0;
                end
                send_pixel(plan[i].px, plan[i].pinned, '{plan[i].exp_px, plan[i].exp_last});
            end
        end

        // Random phases: fresh settings each time, mostly whole small frames.
        random_sent = 0;
        while (random_sent < RANDOM_PIX) begin
            wait_idle(4);
            case ($urandom_range(0, 9))
                0:       w = 0;
                1:       w = MAX_W;
                2:       w = 8191;
                3:       w = 1;
                default: w = $urandom_range(2, 12);
            endcase
            case ($urandom_range(0, 9))
                0:       h = 0;
                1:       h = 65535;
                2:       h = 1;
                default: h = $urandom_range(2, 6);
            endcase
            enc_bit    = $urandom_range(0, 1);
            single_bit = $urandom_range(0, 1);
            write_reg(REG_ENCODE_MODE, {15'($urandom), enc_bit});
            write_reg(REG_SINGLE_CHANNEL, {15'($urandom), single_bit});
            write_reg(REG_IMAGE_WIDTH, {3'($urandom), 13'(w)});
            write_reg(REG_IMAGE_HEIGHT, 16'(h));
            cfg_we <= 1'b0;
            settings_used++;

            ew = eff_width(13'(w));
            eh = eff_height(16'(h));
            n  = (ew * eh <= 40) ? ew * eh * $urandom_range(1, 3) : $urandom_range(20, 50);

            // Every few phases run flat out on one side or on both.
            tx_idle_on = ($urandom_range(0, 3) != 0);
            rx_idle_on = ($urandom_range(0, 3) != 0);
            // In the second phase, hold the receiver off long enough to back up the pipe.
            if (settings_used == 8) begin
                rx_hold_cycles = HOLD_LONG;
                if (n < 30) n = 30;
            end
            flip_mode = ($urandom_range(0, 1) == 1) && (n >= 4);

            for (k = 0; k < n; k++) begin
                // Halfway through, in some phases, flip a mode bit; position is kept.
                if (flip_mode && k == n / 2) begin
                    wait_idle(4);
                    if ($urandom_range(0, 1)) write_reg(REG_ENCODE_MODE, {15'($urandom), ~enc_mode});
                    else write_reg(REG_SINGLE_CHANNEL, {15'($urandom), ~single_mode});
                    cfg_we <= 1'b0;
                end
                send_pixel(pixel_t'($urandom), 1'b0, '0);
                random_sent++;
            end
        end

        // Drain and let the pipe settle so that any stray result shows.
        wait_idle(8);

        $display("%0d pixel requests over %0d register settings, %0d results compared",
                 pixels_sent, settings_used, results_seen);
        $display("%0d frame ends, %0d field mismatches", frames_closed, mismatches);
        if (mismatches == 0) begin
            $display("average_predictor_image_filter: match");
        end else begin
            $display("average_predictor_image_filter: mismatch");
        end
        $finish;
    end

endmodule

>>> sim.f
design/apif_pkg.sv
design/apif_frame_ctl.sv
design/apif_predict.sv
design/average_predictor_image_filter.sv
tb/average_predictor_image_filter_tb.sv
